/* design/spz_pkg.sv */
// ----------------------------------------------------------------------------
// spz_pkg
// Shared types and constants of the sponge hash: action codes, the
// permutation geometry, the whip length and the memory request bundle.
// ----------------------------------------------------------------------------
package spz_pkg;

  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;

  localparam int WHIP_ROUNDS = 512;
  localparam int RND_W       = (WHIP_ROUNDS > 1) ? $clog2(WHIP_ROUNDS) : 1;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ABSORB  = 2'd1,
    ACT_SQUEEZE = 2'd2
  } action_e;

  // one cycle worth of permutation memory traffic
  typedef struct packed {
    logic  clr;
    logic  we;
    byte_t waddr;
    byte_t wdata;
    byte_t raddr;
  } mem_req_t;

endpackage

/* design/spz_if.sv */
// ----------------------------------------------------------------------------
// spz_if
// Valid/ready channels of the sponge hash: the action channel in and the
// squeezed byte channel out.
// ----------------------------------------------------------------------------
interface spz_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface spz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] hash_byte;

  modport source (output valid, output hash_byte, input ready);
  modport sink   (input valid, input hash_byte, output ready);
endinterface

/* design/spz_ram.sv */
// ----------------------------------------------------------------------------
// spz_ram
// Generic single write port, single read port RAM with registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module spz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/spz_perm_mem.sv */
// ----------------------------------------------------------------------------
// spz_perm_mem
// Permutation store: RAM plus per-entry valid bits so that an unwritten
// entry reads as its own index, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module spz_perm_mem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spz_pkg::mem_req_t req_i,
  output spz_pkg::byte_t    rdata_o
);
  import spz_pkg::*;

  logic [PERM_DEPTH-1:0] vld_q;
  logic [PERM_DEPTH-1:0] vld_d;
  byte_t                 ram_rdata;
  logic                  rd_vld_q;
  byte_t                 rd_addr_q;
  logic                  fwd_q;
  byte_t                 fwd_val_q;

  spz_ram #(
    .WIDTH (8),
    .DEPTH (PERM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    vld_d = vld_q;
    if (req_i.clr) begin
      vld_d = '0;
    end else if (req_i.we) begin
      vld_d[req_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // side info for the read in flight
  always_ff @(posedge clk_i) begin
    rd_vld_q  <= vld_q[req_i.raddr];
    rd_addr_q <= req_i.raddr;
    fwd_q     <= req_i.we && (req_i.waddr == req_i.raddr);
    fwd_val_q <= req_i.wdata;
  end

  assign rdata_o = fwd_q    ? fwd_val_q :
                   rd_vld_q ? ram_rdata : rd_addr_q;

endmodule

/* design/spritz_sponge_hash.sv */
// ----------------------------------------------------------------------------
// spritz_sponge_hash
// Sponge hash over a 256-byte permutation held in one synchronous RAM. An
// init transaction restores the reset state and gives no output. An
// absorb transaction does two nibble swaps; every 64th byte also triggers
// a shuffle of 2*WHIP_ROUNDS updates, which runs at the start of the
// following nibble. A squeeze runs one update and the output chain, after
// a shuffle when anything was absorbed since the last shuffle. The update
// rate is set by the chain of three dependent permutation reads through the
// single RAM read port; the write-back of one update overlaps the first
// read of the next. The output register lets a new transaction start while
// a byte waits.
// ----------------------------------------------------------------------------
module spritz_sponge_hash (
  input  logic      clk_i,
  input  logic      rst_ni,
  spz_in_if.sink    in_i,
  spz_out_if.source out_o
);
  import spz_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AB1  = 4'd1;
  localparam logic [3:0] S_AB2  = 4'd2;
  localparam logic [3:0] S_AB3  = 4'd3;
  localparam logic [3:0] S_AB4  = 4'd4;
  localparam logic [3:0] S_U1   = 4'd5;
  localparam logic [3:0] S_U2   = 4'd6;
  localparam logic [3:0] S_U3   = 4'd7;
  localparam logic [3:0] S_U4   = 4'd8;
  localparam logic [3:0] S_U5   = 4'd9;
  localparam logic [3:0] S_O2   = 4'd10;
  localparam logic [3:0] S_O3   = 4'd11;
  localparam logic [3:0] S_O4   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(WHIP_ROUNDS - 1);

  logic [3:0]       state_q, state_d;
  byte_t            i_q, i_d, j_q, j_d, k_q, k_d;
  byte_t            stride_q, stride_d;
  byte_t            last_q, last_d;
  byte_t            cnt_q, cnt_d;
  byte_t            si_q, si_d;
  byte_t            byte_q, byte_d;
  logic             nib_q, nib_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic             whip_q, whip_d;
  logic             single_q, single_d;
  logic             ret_sq_q, ret_sq_d;
  logic             out_valid_q, out_valid_d;
  byte_t            out_data_q, out_data_d;

  mem_req_t req;
  byte_t    rd;
  logic     in_acc;
  logic [3:0] nib_val;
  logic     whip_end;
  logic     shuf_done;
  byte_t    stride_n;

  spz_perm_mem u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rd)
  );

  assign in_i.ready      = (state_q == S_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.hash_byte = out_data_q;

  assign nib_val   = nib_q ? byte_q[7:4] : byte_q[3:0];
  assign whip_end  = (rnd_q == RND_LAST);
  assign shuf_done = whip_end && whip_q;
  assign stride_n  = whip_end ? byte_t'(stride_q + 8'd2) : stride_q;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    stride_d    = stride_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    si_d        = si_q;
    byte_d      = byte_q;
    nib_d       = nib_q;
    rnd_d       = rnd_q;
    whip_d      = whip_q;
    single_d    = single_q;
    ret_sq_d    = ret_sq_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    req         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.action)
            ACT_INIT: begin
              req.clr  = 1'b1;
              i_d      = '0;
              j_d      = '0;
              k_d      = '0;
              last_d   = '0;
              cnt_d    = '0;
              stride_d = 8'd1;
            end
            ACT_ABSORB: begin
              byte_d  = in_i.data_byte;
              nib_d   = 1'b0;
              state_d = S_AB1;
            end
            ACT_SQUEEZE: begin
              single_d = (cnt_q == '0);
              ret_sq_d = 1'b1;
              state_d  = S_U1;
            end
            default: begin
            end
          endcase
        end
      end
      S_AB1: begin
        if (cnt_q[7]) begin
          // count reached 128: shuffle first, then come back here
          single_d = 1'b0;
          ret_sq_d = 1'b0;
          state_d  = S_U1;
        end else begin
          req.raddr = cnt_q;
          state_d   = S_AB2;
        end
      end
      S_AB2: begin
        si_d      = rd;
        req.raddr = {1'b1, 3'd0, nib_val};
        state_d   = S_AB3;
      end
      S_AB3: begin
        req.we    = 1'b1;
        req.waddr = cnt_q;
        req.wdata = rd;
        state_d   = S_AB4;
      end
      S_AB4: begin
        req.we    = 1'b1;
        req.waddr = {1'b1, 3'd0, nib_val};
        req.wdata = si_q;
        cnt_d     = byte_t'(cnt_q + 8'd1);
        nib_d     = 1'b1;
        state_d   = nib_q ? S_IDLE : S_AB1;
      end
      S_U1: begin
        i_d       = byte_t'(i_q + stride_q);
        req.raddr = i_d;
        state_d   = S_U2;
      end
      S_U2: begin
        si_d      = rd;
        req.raddr = byte_t'(j_q + rd);
        state_d   = S_U3;
      end
      S_U3: begin
        j_d       = byte_t'(k_q + rd);
        req.raddr = j_d;
        state_d   = S_U4;
      end
      S_U4: begin
        k_d       = byte_t'(i_q + k_q + rd);
        req.we    = 1'b1;
        req.waddr = i_q;
        req.wdata = rd;
        state_d   = S_U5;
      end
      S_U5: begin
        req.we    = 1'b1;
        req.waddr = j_q;
        req.wdata = si_q;
        if (single_q) begin
          // update done, start the output chain
          req.raddr = byte_t'(last_q + k_q);
          state_d   = S_O2;
        end else begin
          rnd_d    = whip_end ? '0 : RND_W'(rnd_q + 1'b1);
          stride_d = stride_n;
          whip_d   = whip_q ^ whip_end;
          if (shuf_done) begin
            cnt_d    = '0;
            single_d = 1'b1;
          end
          if (shuf_done && !ret_sq_q) begin
            state_d = S_AB1;
          end else begin
            // overlap the first read of the next update
            i_d       = byte_t'(i_q + stride_n);
            req.raddr = i_d;
            state_d   = S_U2;
          end
        end
      end
      S_O2: begin
        req.raddr = byte_t'(i_q + rd);
        state_d   = S_O3;
      end
      S_O3: begin
        req.raddr = byte_t'(j_q + rd);
        state_d   = S_O4;
      end
      S_O4: begin
        last_d  = rd;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = last_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      stride_q    <= 8'd1;
      last_q      <= '0;
      cnt_q       <= '0;
      nib_q       <= 1'b0;
      rnd_q       <= '0;
      whip_q      <= 1'b0;
      single_q    <= 1'b0;
      ret_sq_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      stride_q    <= stride_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      nib_q       <= nib_d;
      rnd_q       <= rnd_d;
      whip_q      <= whip_d;
      single_q    <= single_d;
      ret_sq_q    <= ret_sq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    byte_q     <= byte_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTH
  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("output valid raised outside of the final state");

  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (rnd_q == '0 && !whip_q))
    else $error("whip counters not cleared when idle");

  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.action == ACT_INIT) |=> (cnt_q == '0 && stride_q == 8'd1))
    else $error("init transaction did not restore registers");

  a_swap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AB2) |-> !cnt_q[7])
    else $error("nibble swap issued with full absorb count");
`endif

endmodule
